// ----- design/swm_pkg.sv -----
`default_nettype none
package swm_pkg;

    localparam int WL_WIDTH = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_PUSH,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_tail;
        logic head_pop;
        logic tail_pop;
        logic push;
        logic out_load;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic head_expired;
        logic tail_dominated;
        logic win_full;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- design/swm_in_if.sv -----
`default_nettype none
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface
`default_nettype wire

// ----- design/swm_out_if.sv -----
`default_nettype none
interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           final_result;

    modport source (output valid, window_max, final_result, input ready);
    modport sink   (input valid, window_max, final_result, output ready);
endinterface
`default_nettype wire

// ----- design/swm_cfg_if.sv -----
`default_nettype none
interface swm_cfg_if;
    import swm_pkg::*;

    logic                valid;
    logic                ready;
    logic [WL_WIDTH-1:0] window_length;

    modport source (output valid, window_length, input ready);
    modport sink   (input valid, window_length, output ready);
endinterface
`default_nettype wire

// ----- design/sliding_window_maximum_unit.sv -----
`default_nettype none
// Running maximum over the last window_length signed samples of a sequence
// (window_length 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW).
// Candidates live in a monotonic deque held in a single-port-read memory
// of MAX_WINDOW entries, so each sample is worked on alone: accept, head
// check, tail check, append, head read and result load; an empty deque
// skips both checks, head read and result load follow only once the
// window is full, each candidate dropped from either end costs another read
// and check, and the result load waits for the result register to free. The
// one read port of the candidate memory serialises these steps. No result appears until
// window_length samples of the sequence have arrived; last_sample is echoed
// on final_result and clears the sequence state once the item is done. The
// result register lets the next sample start while a result waits. The
// window register may be written only while the block is idle.
module sliding_window_maximum_unit #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input wire logic   clk,
    input wire logic   rst_n,
    swm_in_if.sink     samples,
    swm_out_if.source  results,
    swm_cfg_if.sink    cfg
);
    import swm_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    assign cfg.ready = 1'b1;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    swm_dp #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_sample (samples.sample),
        .in_last   (samples.last_sample),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_data  (cfg.window_length),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_max   (results.window_max),
        .out_final (results.final_result)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.head_pop || cmd.tail_pop) |-> !status.count_zero)
        else $error("pop from an empty deque");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second item taken while one is in flight");

    a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (state == S_PUSH) ##1 !cmd.push)
        else $error("append repeated for one item");
endmodule
`default_nettype wire

// ----- design/swm_ram.sv -----
`default_nettype none
module swm_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/swm_ctrl.sv -----
`default_nettype none
module swm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire swm_pkg::status_t status,
    output swm_pkg::cmd_t         cmd,
    output swm_pkg::state_t       state
);
    import swm_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HEAD_RD;
                end
            end
            S_HEAD_RD:
            begin
                state_next = status.count_zero ? S_PUSH : S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                if (status.head_expired)
                begin
                    cmd.head_pop = 1'b1;
                    state_next   = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_TAIL_RD;
                end
            end
            S_TAIL_RD:
            begin
                cmd.rd_tail = 1'b1;
                state_next  = status.count_zero ? S_PUSH : S_TAIL_CHK;
            end
            S_TAIL_CHK:
            begin
                if (status.tail_dominated)
                begin
                    cmd.tail_pop = 1'b1;
                    state_next   = S_TAIL_RD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (status.win_full)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- design/swm_dp.sv -----
`default_nettype none
module swm_dp #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire swm_pkg::cmd_t                     cmd,
    output swm_pkg::status_t                       status,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sample,
    input  wire logic                              in_last,
    input  wire logic                              cfg_we,
    input  wire logic [swm_pkg::WL_WIDTH-1:0]      cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         out_max,
    output logic                                   out_final
);
    import swm_pkg::*;

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int PW   = $clog2(2 * MAX_WINDOW);
    localparam int WLE  = (CW > WL_WIDTH) ? CW : WL_WIDTH;
    localparam int EW   = SAMPLE_WIDTH + PW;
    localparam logic [AW-1:0] IDX_LAST  = AW'(MAX_WINDOW - 1);
    localparam logic [PW-1:0] POS_LAST  = PW'(2 * MAX_WINDOW - 1);
    localparam logic [PW:0]   POS_MOD   = (PW + 1)'(2 * MAX_WINDOW);
    localparam logic [WLE-1:0] WIN_MAX  = WLE'(MAX_WINDOW);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           last_reg;
    logic [WL_WIDTH-1:0]            wl_reg;
    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [PW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  fill_reg, fill_next;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic                           final_reg;

    logic [AW-1:0]                  head_inc, tail_inc, tail_dec;
    logic [AW-1:0]                  raddr;
    logic [EW-1:0]                  rdata;
    logic signed [SAMPLE_WIDTH-1:0] rd_value;
    logic [PW-1:0]                  rd_pos;
    logic [PW:0]                    age;
    logic [WLE-1:0]                 wl_ext;
    logic [CW-1:0]                  win;
    logic [CW-1:0]                  fill_sat;

    // effective window, clamped to 1..MAX_WINDOW
    always_comb
    begin
        wl_ext = WLE'(wl_reg);
        if (wl_reg == '0)
        begin
            win = CW'(1);
        end
        else if (wl_ext > WIN_MAX)
        begin
            win = CW'(MAX_WINDOW);
        end
        else
        begin
            win = CW'(wl_ext);
        end
    end

    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - AW'(1);
    assign raddr    = cmd.rd_tail ? tail_dec : head_reg;

    swm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata ({sample_reg, pos_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_value = rdata[EW-1:PW];
    assign rd_pos   = rdata[PW-1:0];

    // age modulo twice the window capacity
    always_comb
    begin
        if (pos_reg >= rd_pos)
        begin
            age = {1'b0, pos_reg} - {1'b0, rd_pos};
        end
        else
        begin
            age = {1'b0, pos_reg} + POS_MOD - {1'b0, rd_pos};
        end
    end

    assign fill_sat = (fill_reg < win) ? fill_reg + CW'(1) : win;

    assign status.count_zero     = (count_reg == '0);
    assign status.head_expired   = (age >= (PW + 1)'(win));
    assign status.tail_dominated = (rd_value <= sample_reg);
    assign status.win_full       = (fill_sat == win);
    assign status.out_free       = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        if (cmd.head_pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end
        if (cmd.tail_pop)
        begin
            tail_next  = tail_dec;
            count_next = count_reg - CW'(1);
        end
        if (cmd.push)
        begin
            tail_next  = tail_inc;
            count_next = count_reg + CW'(1);
            pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
            fill_next  = fill_sat;
        end
        // end of sequence wipes the deque
        if (cmd.finish && last_reg)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            pos_next   = '0;
            fill_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= WL_WIDTH'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wl_reg <= cfg_data;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
        end
        if (cmd.out_load)
        begin
            max_reg   <= rd_value;
            final_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_max   = max_reg;
    assign out_final = final_reg;
endmodule
`default_nettype wire
